>>> hw/rtl/hsha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Shared types, constants and helpers for the front queue, sequencer and core.
// ----------------------------------------------------------------------------
package hsha_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [7:0] IpadByte = 8'h36;
   localparam logic [7:0] OpadByte = 8'h5c;
   localparam logic [7:0] PadMarker = 8'h80;

   localparam logic [6:0] BlockBytes = 7'd64;
   localparam logic [6:0] DigestBytes = 7'd20;
   localparam logic [5:0] LenSlot = 6'd56;
   localparam logic [63:0] OuterBits = 64'd672;

   localparam logic [159:0] ChainInit = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       present;
      logic       last;
   } item_type;

   typedef struct packed {
      logic start;
      logic init;
   } sha_cmd_type;

   typedef enum logic [1:0] {
      SRC_KEY,
      SRC_KEYPAD,
      SRC_BUF,
      SRC_PAD
   } src_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_KEYBYTE,
      ST_ABSORB,
      ST_BLOCK,
      ST_CLOSE,
      ST_FIN1,
      ST_FIN2,
      ST_KEYDIG,
      ST_IPAD,
      ST_OPENED,
      ST_MSGBYTE,
      ST_FINAL,
      ST_OUTER,
      ST_EMIT,
      ST_OUT,
      ST_WAIT
   } state_type;

   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
      rol = (x << n) | (x >> (32 - n));
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hsha_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HMAC-SHA1 front queue
// Accepts request beats, decodes them into items and queues them for the back.
// ----------------------------------------------------------------------------
module hsha_front #(
   parameter int unsigned DEPTH = hsha_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              req_tuser,
   output logic                   q_valid,
   output hsha_pkg::item_type     q_item,
   input  wire logic              q_pop
);
   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   hsha_pkg::item_type  slot_ff [DEPTH];
   logic [PtrW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   hsha_pkg::item_type  beat;
   logic                push;

   always_comb begin
      beat.cmd     = req_tuser;
      beat.data    = req_tdata[7:0];
      beat.present = req_tdata[8];
      beat.last    = req_tlast;
      req_tready   = (count_ff != CntW'(DEPTH));
      q_valid      = (count_ff != '0);
      q_item       = slot_ff[rptr_ff];
      push         = req_tvalid && req_tready;
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      if (push) begin
         wptr_in = (wptr_ff == PtrW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == PtrW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= beat;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/hsha_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HMAC-SHA1 compression core
// One SHA-1 round per cycle over a 16-word schedule window, then chain update.
// ----------------------------------------------------------------------------
module hsha_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hsha_pkg::sha_cmd_type cmd,
   input  wire logic [511:0]          blk,
   output logic                       busy,
   output logic [159:0]               chain
);
   logic [15:0][31:0] w_ff, w_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [159:0]      chain_ff, chain_in, base;
   logic [6:0]        round_ff, round_in;
   logic              busy_ff, busy_in;
   logic [31:0]       f, k, t, wnew;

   assign busy  = busy_ff;
   assign chain = chain_ff;

   always_comb begin
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = 32'h5A827999;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'h6ED9EBA1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'hCA62C1D6;
      end
      t    = hsha_pkg::rol(a_ff, 5) + f + e_ff + k + w_ff[0];
      wnew = hsha_pkg::rol(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
      base = cmd.init ? hsha_pkg::ChainInit : chain_ff;

      w_in = w_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      chain_in = chain_ff; round_in = round_ff; busy_in = busy_ff;

      if (!busy_ff) begin
         if (cmd.start) begin
            for (int j = 0; j < 16; j++) begin
               w_in[j] = blk[511-32*j -: 32];
            end
            {a_in, b_in, c_in, d_in, e_in} = base;
            chain_in = base;
            round_in = '0;
            busy_in  = 1'b1;
         end
      end else if (round_ff == 7'd80) begin
         // fold the working variables back into the chain
         chain_in = {chain_ff[159:128] + a_ff, chain_ff[127:96] + b_ff,
                     chain_ff[95:64] + c_ff, chain_ff[63:32] + d_ff, chain_ff[31:0] + e_ff};
         busy_in  = 1'b0;
      end else begin
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j+1];
         end
         w_in[15] = wnew;
         e_in = d_ff;
         d_in = c_ff;
         c_in = hsha_pkg::rol(b_ff, 30);
         b_in = a_ff;
         a_in = t;
         round_in = round_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
      end
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      chain_ff <= chain_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/hsha_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HMAC-SHA1 back sequencer
// Carries out queued items: key collection, absorb, padding, digest output.
// ----------------------------------------------------------------------------
module hsha_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire hsha_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tuser
);
   hsha_pkg::state_type   state_ff, state_in, ret_ff, ret_in, fret_ff, fret_in, after;
   hsha_pkg::item_type    item_ff, item_in;
   hsha_pkg::sha_cmd_type sha_cmd;
   hsha_pkg::src_type     src;
   logic [511:0] key_ff, key_in, buf_ff, buf_in, blk, padblk;
   logic [6:0]   kcount_ff, kcount_in;
   logic         hashed_ff, hashed_in, phase_ff, phase_in, ovf_ff, ovf_in;
   logic [60:0]  mcount_ff, mcount_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in, mlen;
   logic [159:0] digest_ff, digest_in, chain;
   logic         ovfout_ff, ovfout_in, sha_busy;
   logic [2:0]   widx_ff, widx_in;
   logic [7:0]   pad;

   hsha_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (sha_cmd),
      .blk   (blk),
      .busy  (sha_busy),
      .chain (chain)
   );

   // final block(s): marker after the fill, zeros, length in the last eight bytes
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         if (6'(i) < fill_ff) begin
            padblk[511-8*i -: 8] = buf_ff[511-8*i -: 8];
         end else if (6'(i) == fill_ff) begin
            padblk[511-8*i -: 8] = hsha_pkg::PadMarker;
         end else begin
            padblk[511-8*i -: 8] = 8'h00;
         end
      end
      if (fill_ff < hsha_pkg::LenSlot) begin
         padblk[63:0] = len_ff;
      end
   end

   always_comb begin
      case (src)
         hsha_pkg::SRC_KEY:    blk = key_ff;
         hsha_pkg::SRC_KEYPAD: blk = key_ff ^ {64{pad}};
         hsha_pkg::SRC_BUF:    blk = buf_ff;
         hsha_pkg::SRC_PAD:    blk = (state_ff == hsha_pkg::ST_FIN2) ? {448'b0, len_ff} : padblk;
         default:              blk = buf_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; fret_in = fret_ff; item_in = item_ff;
      key_in = key_ff; buf_in = buf_ff; kcount_in = kcount_ff; hashed_in = hashed_ff;
      phase_in = phase_ff; ovf_in = ovf_ff; mcount_in = mcount_ff; fill_in = fill_ff;
      len_in = len_ff; digest_in = digest_ff; ovfout_in = ovfout_ff; widx_in = widx_ff;
      sha_cmd = '0; src = hsha_pkg::SRC_BUF; pad = hsha_pkg::IpadByte; q_pop = 1'b0;
      rsp_tvalid = 1'b0;
      mlen = {3'b000, mcount_ff} + 64'(hsha_pkg::BlockBytes);
      if (item_ff.last) begin
         after = item_ff.cmd ? hsha_pkg::ST_FINAL : hsha_pkg::ST_CLOSE;
      end else begin
         after = hsha_pkg::ST_IDLE;
      end

      case (state_ff)
         hsha_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = hsha_pkg::ST_DISPATCH;
            end
         end
         hsha_pkg::ST_DISPATCH: begin
            if (!item_ff.cmd) begin
               if (phase_ff) begin
                  // key during message: drop the message and start over
                  key_in = '0; kcount_in = '0; hashed_in = 1'b0;
                  mcount_in = '0; phase_in = 1'b0; ovf_in = 1'b0;
               end else begin
                  state_in = hsha_pkg::ST_KEYBYTE;
               end
            end else if (!phase_ff) begin
               state_in = hsha_pkg::ST_CLOSE;
            end else begin
               state_in = hsha_pkg::ST_MSGBYTE;
            end
         end
         hsha_pkg::ST_KEYBYTE: begin
            if (item_ff.present) begin
               if (!hashed_ff && !kcount_ff[6]) begin
                  key_in[511-8*kcount_ff[5:0] -: 8] = item_ff.data;
                  kcount_in = kcount_ff + 1'b1;
                  state_in  = after;
               end else if (!hashed_ff) begin
                  hashed_in     = 1'b1;
                  sha_cmd.start = 1'b1;
                  sha_cmd.init  = 1'b1;
                  src           = hsha_pkg::SRC_KEY;
                  mcount_in     = 61'(hsha_pkg::BlockBytes);
                  ret_in        = hsha_pkg::ST_ABSORB;
                  state_in      = hsha_pkg::ST_WAIT;
               end else begin
                  state_in = hsha_pkg::ST_ABSORB;
               end
            end else begin
               state_in = after;
            end
         end
         hsha_pkg::ST_ABSORB: begin
            if (&mcount_ff) begin
               ovf_in   = 1'b1;
               state_in = after;
            end else begin
               buf_in[511-8*mcount_ff[5:0] -: 8] = item_ff.data;
               mcount_in = mcount_ff + 1'b1;
               state_in  = (&mcount_ff[5:0]) ? hsha_pkg::ST_BLOCK : after;
            end
         end
         hsha_pkg::ST_BLOCK: begin
            sha_cmd.start = 1'b1;
            src           = hsha_pkg::SRC_BUF;
            ret_in        = after;
            state_in      = hsha_pkg::ST_WAIT;
         end
         hsha_pkg::ST_CLOSE: begin
            if (hashed_ff) begin
               fill_in  = mcount_ff[5:0];
               len_in   = {mcount_ff, 3'b000};
               fret_in  = hsha_pkg::ST_KEYDIG;
               state_in = hsha_pkg::ST_FIN1;
            end else begin
               state_in = hsha_pkg::ST_IPAD;
            end
         end
         hsha_pkg::ST_FIN1: begin
            sha_cmd.start = 1'b1;
            src           = hsha_pkg::SRC_PAD;
            ret_in        = (fill_ff >= hsha_pkg::LenSlot) ? hsha_pkg::ST_FIN2 : fret_ff;
            state_in      = hsha_pkg::ST_WAIT;
         end
         hsha_pkg::ST_FIN2: begin
            sha_cmd.start = 1'b1;
            src           = hsha_pkg::SRC_PAD;
            ret_in        = fret_ff;
            state_in      = hsha_pkg::ST_WAIT;
         end
         hsha_pkg::ST_KEYDIG: begin
            key_in    = {chain, 352'b0};
            kcount_in = hsha_pkg::DigestBytes;
            hashed_in = 1'b0;
            state_in  = hsha_pkg::ST_IPAD;
         end
         hsha_pkg::ST_IPAD: begin
            sha_cmd.start = 1'b1;
            sha_cmd.init  = 1'b1;
            src           = hsha_pkg::SRC_KEYPAD;
            mcount_in     = '0;
            phase_in      = 1'b1;
            ret_in        = hsha_pkg::ST_OPENED;
            state_in      = hsha_pkg::ST_WAIT;
         end
         hsha_pkg::ST_OPENED: begin
            state_in = item_ff.cmd ? hsha_pkg::ST_MSGBYTE : hsha_pkg::ST_IDLE;
         end
         hsha_pkg::ST_MSGBYTE: begin
            state_in = item_ff.present ? hsha_pkg::ST_ABSORB : after;
         end
         hsha_pkg::ST_FINAL: begin
            fill_in  = mcount_ff[5:0];
            len_in   = {mlen[60:0], 3'b000};
            fret_in  = hsha_pkg::ST_OUTER;
            state_in = hsha_pkg::ST_FIN1;
         end
         hsha_pkg::ST_OUTER: begin
            buf_in        = {chain, buf_ff[351:0]};
            fill_in       = 6'(hsha_pkg::DigestBytes);
            len_in        = hsha_pkg::OuterBits;
            sha_cmd.start = 1'b1;
            sha_cmd.init  = 1'b1;
            src           = hsha_pkg::SRC_KEYPAD;
            pad           = hsha_pkg::OpadByte;
            fret_in       = hsha_pkg::ST_EMIT;
            ret_in        = hsha_pkg::ST_FIN1;
            state_in      = hsha_pkg::ST_WAIT;
         end
         hsha_pkg::ST_EMIT: begin
            digest_in = chain;
            ovfout_in = ovf_ff;
            widx_in   = '0;
            key_in = '0; kcount_in = '0; hashed_in = 1'b0;
            mcount_in = '0; phase_in = 1'b0; ovf_in = 1'b0;
            state_in  = hsha_pkg::ST_OUT;
         end
         hsha_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (widx_ff == 3'd4) begin
                  state_in = hsha_pkg::ST_IDLE;
               end else begin
                  widx_in = widx_ff + 1'b1;
               end
            end
         end
         hsha_pkg::ST_WAIT: begin
            if (!sha_busy) begin
               state_in = ret_ff;
            end
         end
         default: state_in = hsha_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tdata = digest_ff[159-32*widx_ff -: 32];
   assign rsp_tlast = (widx_ff == 3'd4);
   assign rsp_tuser = ovfout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hsha_pkg::ST_IDLE;
         key_ff    <= '0;
         kcount_ff <= '0;
         hashed_ff <= 1'b0;
         phase_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
         mcount_ff <= '0;
         widx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         key_ff    <= key_in;
         kcount_ff <= kcount_in;
         hashed_ff <= hashed_in;
         phase_ff  <= phase_in;
         ovf_ff    <= ovf_in;
         mcount_ff <= mcount_in;
         widx_ff   <= widx_in;
      end
      ret_ff    <= ret_in;
      fret_ff   <= fret_in;
      item_ff   <= item_in;
      buf_ff    <= buf_in;
      fill_ff   <= fill_in;
      len_ff    <= len_in;
      digest_ff <= digest_in;
      ovfout_ff <= ovfout_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/hmac_sha1_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine
// Key bytes, then message bytes in; five big-endian HMAC words out.
// ----------------------------------------------------------------------------
// Send the key as beats with tuser low, then the message with tuser high; tlast
// ends each, and a beat with tdata[8] low carries no byte. The HMAC leaves as
// five 32-bit words, most significant first, tlast on the fifth. Every 64th
// hashed byte (a message byte, or a key byte past the 64th) adds one compression
// in the single-round SHA-1 core, for which the sequencer waits. Closing a key
// takes one compression, or two to three if the key was over 64 bytes. The
// digest takes three more compressions (four when the last message block holds
// 56 or more bytes), then the five output beats. A small input queue keeps
// taking beats meanwhile.
module hmac_sha1_engine #(
   parameter int unsigned QUEUE_DEPTH = hsha_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // data_byte, byte_present, zero fill
   input  wire logic        req_tlast,   // last_byte
   input  wire logic        req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word
   output logic             rsp_tlast,   // last_word
   output logic             rsp_tuser    // length_overflow
);
   logic               q_valid, q_pop;
   hsha_pkg::item_type q_item;

   hsha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   hsha_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine testbench
// Streams keys and messages into the engine with random gaps and back
// pressure, predicts each HMAC in a behavioral model and checks every beat.
// ----------------------------------------------------------------------------
module tb;

   localparam logic       CMD_KEY = 1'b0;
   localparam logic       CMD_MSG = 1'b1;
   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;
   localparam logic [63:0] LEN_MAX = 64'h1FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       present;
      logic       last;
   } beat_t;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
      logic        ovf;
   } mac_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   hmac_sha1_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // model state
   logic [7:0]  key_blk [64];
   int unsigned key_cnt;
   logic        key_hashed;
   logic [31:0] hv [5];
   logic [7:0]  buf_blk [64];
   logic [63:0] byte_cnt;
   logic        in_msg;
   logic        ovf;

   beat_t     pending_beats [$];
   mac_word_t expected_words [$];
   int        errors = 0;
   bit        stim_done = 0;
   logic      hold_sink = 1'b0;

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic hv_init();
      hv[0] = 32'h67452301; hv[1] = 32'hEFCDAB89; hv[2] = 32'h98BADCFE;
      hv[3] = 32'h10325476; hv[4] = 32'hC3D2E1F0;
   endtask

   task automatic compress(input logic [7:0] blk [64]);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d; hv[4] += e;
   endtask

   task automatic model_reset();
      foreach (key_blk[i]) key_blk[i] = '0;
      foreach (buf_blk[i]) buf_blk[i] = '0;
      key_cnt = 0; key_hashed = 0; byte_cnt = '0; in_msg = 0; ovf = 0;
      hv_init();
   endtask

   task automatic absorb(input logic [7:0] b);
      if (byte_cnt >= LEN_MAX) begin
         ovf = 1;
      end else begin
         buf_blk[byte_cnt[5:0]] = b;
         byte_cnt++;
         if (byte_cnt[5:0] == 0) compress(buf_blk);
      end
   endtask

   // pad, append bit length, compress; digest ends up in hv
   task automatic finish_hash(input int fill, input logic [63:0] bits);
      fill = fill & 63;
      buf_blk[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) buf_blk[i] = '0;
      if (fill >= 56) begin
         compress(buf_blk);
         foreach (buf_blk[i]) buf_blk[i] = '0;
      end
      for (int i = 0; i < 8; i++) buf_blk[56+i] = bits[63-8*i -: 8];
      compress(buf_blk);
   endtask

   task automatic pad_key(input logic [7:0] pad);
      logic [7:0] tmp [64];
      foreach (tmp[i]) tmp[i] = key_blk[i] ^ pad;
      hv_init();
      compress(tmp);
   endtask

   task automatic close_key();
      if (key_hashed) begin
         finish_hash(int'(byte_cnt[5:0]), byte_cnt << 3);
         foreach (key_blk[i]) key_blk[i] = '0;
         for (int i = 0; i < 20; i++) key_blk[i] = hv[i/4][31-8*(i%4) -: 8];
         key_cnt = 20;
         key_hashed = 0;
      end
      pad_key(IPAD);
      byte_cnt = '0;
      in_msg = 1;
   endtask

   task automatic predict_hmac(input beat_t bt);
      logic [31:0] inner [5];
      if (bt.cmd == CMD_KEY) begin
         if (in_msg) model_reset();
         if (bt.present) begin
            if (!key_hashed && key_cnt < 64) begin
               key_blk[key_cnt] = bt.data;
               key_cnt++;
            end else begin
               if (!key_hashed) begin
                  key_hashed = 1;
                  hv_init();
                  compress(key_blk);
                  byte_cnt = 64;
               end
               absorb(bt.data);
            end
         end
         if (bt.last) close_key();
         return;
      end
      if (!in_msg) close_key();
      if (bt.present) absorb(bt.data);
      if (!bt.last) return;
      finish_hash(int'(byte_cnt[5:0]), (byte_cnt + 64) << 3);
      foreach (inner[i]) inner[i] = hv[i];
      pad_key(OPAD);
      for (int i = 0; i < 20; i++) buf_blk[i] = inner[i/4][31-8*(i%4) -: 8];
      finish_hash(20, 64'd672);
      for (int i = 0; i < 5; i++) expected_words.push_back('{hv[i], i == 4, ovf});
      model_reset();
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               beat_t bt;
               bt = pending_beats.pop_front();
               predict_hmac(bt);
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, bt.present, bt.data};
               req_tlast <= bt.last;
               req_tuser <= bt.cmd;
               req_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and sink back pressure
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report("unexpected beat", rsp_tdata, 0);
            end else begin
               mac_word_t m;
               m = expected_words.pop_front();
               if (rsp_tdata !== m.word) report("digest_word", rsp_tdata, m.word);
               if (rsp_tlast !== m.last) report("last_word", rsp_tlast, m.last);
               if (rsp_tuser !== m.ovf) report("length_overflow", rsp_tuser, m.ovf);
            end
         end
         if (hold_sink) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= gap_len();
         end
      end
   end

   task automatic add_beat(input logic cmd, input logic [7:0] d, input logic p,
                           input logic l);
      pending_beats.push_back('{cmd, d, p, l});
   endtask

   task automatic add_stream(input logic cmd, input int n, input logic absent_end);
      for (int i = 0; i < n; i++)
         add_beat(cmd, 8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !absent_end);
      if (absent_end || n == 0) add_beat(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_drain();
      while (pending_beats.size() > 0 || expected_words.size() > 0) @(posedge clock);
   endtask

   initial begin
      int n;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty key and message, extremes, implicit key close, abandon
      add_beat(CMD_KEY, 8'h00, 1'b0, 1'b1);
      add_beat(CMD_MSG, 8'hff, 1'b0, 1'b1);
      add_beat(CMD_KEY, 8'hff, 1'b1, 1'b0);
      add_beat(CMD_KEY, 8'h00, 1'b1, 1'b1);
      add_beat(CMD_MSG, 8'h00, 1'b1, 1'b0);
      add_beat(CMD_MSG, 8'hff, 1'b1, 1'b1);
      add_beat(CMD_KEY, 8'ha5, 1'b1, 1'b0);
      add_beat(CMD_MSG, 8'h5a, 1'b1, 1'b1);
      add_beat(CMD_KEY, 8'h11, 1'b1, 1'b1);
      add_beat(CMD_MSG, 8'h22, 1'b1, 1'b0);
      add_beat(CMD_KEY, 8'h33, 1'b1, 1'b1);
      add_beat(CMD_MSG, 8'h44, 1'b1, 1'b1);
      add_beat(CMD_MSG, 8'h00, 1'b0, 1'b0);
      add_beat(CMD_MSG, 8'h77, 1'b1, 1'b1);
      wait_drain();

      // hold the sink off while a long key and a second HMAC pile up behind it
      fork
         begin
            hold_sink = 1'b1;
            repeat (3000) @(posedge clock);
            hold_sink = 1'b0;
         end
      join_none
      add_stream(CMD_KEY, 65, 1'b0);
      add_stream(CMD_MSG, 8, 1'b1);
      add_stream(CMD_KEY, 3, 1'b0);
      add_stream(CMD_MSG, 5, 1'b0);
      wait_drain();

      // random HMACs: mostly short streams, a few block-boundary sizes
      while (pending_beats.size() < 30) begin
         case ($urandom_range(0, 9))
            0: n = $urandom_range(55, 70);
            1: n = 0;
            default: n = $urandom_range(1, 8);
         endcase
         if ($urandom_range(0, 3) != 0) add_stream(CMD_KEY, n, $urandom_range(0, 3) == 0);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(54, 66) : $urandom_range(0, 6);
         if ($urandom_range(0, 9) == 0) begin
            add_beat(CMD_MSG, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
            add_stream(CMD_KEY, 2, 1'b0);
         end
         add_stream(CMD_MSG, n, $urandom_range(0, 3) == 0);
      end
      wait_drain();
      repeat (400) @(posedge clock);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (errors == 0) begin
         $display("[hmac_sha1_engine] OK");
      end else begin
         $display("[hmac_sha1_engine] ERROR");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("[hmac_sha1_engine] ERROR");
      $finish;
   end

endmodule
